FILE: rtl/mlfq_scheduler_core_defines.svh
// ---------------------------------------------------------------------------
// mlfq_scheduler_core_defines
// assertion macros for the scheduler core
// ---------------------------------------------------------------------------
`ifndef MLFQ_SCHEDULER_CORE_DEFINES_SVH
`define MLFQ_SCHEDULER_CORE_DEFINES_SVH

// implication checked every clock outside reset
`define MLFQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define MLFQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mlfq_pkg.sv
// ---------------------------------------------------------------------------
// mlfq_pkg
// types and codes shared by the scheduler controller and datapath
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package mlfq_pkg;

    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_UNBLOCK = 3'd1;
    localparam logic [2:0] REQ_TICK    = 3'd2;
    localparam logic [2:0] REQ_BLOCK   = 3'd3;
    localparam logic [2:0] REQ_EXIT    = 3'd4;

    localparam logic [2:0] CFG_LEVELS = 3'd0;
    localparam logic [2:0] CFG_Q0     = 3'd1;
    localparam logic [2:0] CFG_Q1     = 3'd2;
    localparam logic [2:0] CFG_Q2     = 3'd3;
    localparam logic [2:0] CFG_Q3     = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BSCAN,
        ST_FSCAN,
        ST_PUSH,
        ST_DSCAN,
        ST_DREAD,
        ST_DWAIT,
        ST_DTAKE,
        ST_OUT
    } ctrl_state_t;

    // push source select
    typedef enum logic [1:0] {
        PSRC_LOAD,
        PSRC_UNBLOCK,
        PSRC_EXPIRE
    } push_src_t;

    typedef struct packed {
        logic      latch_req;
        logic      bscan_start;
        logic      bscan_step;
        logic      unblock_take;
        logic      fscan_start;
        logic      fscan_step;
        logic      block_store;
        logic      set_ovf;
        logic      push;
        push_src_t push_src;
        logic      tick_dec;
        logic      disp_start;
        logic      disp_step;
        logic      disp_read;
        logic      disp_take;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       tick_gt1;
        logic       cur_valid;
        logic       bscan_done;
        logic       bscan_hit;
        logic       fscan_done;
        logic       fscan_found;
        logic       push_full;
        logic       disp_done;
        logic       disp_found;
    } dp_status_t;

endpackage

FILE: rtl/mlfq_ram.sv
// ---------------------------------------------------------------------------
// mlfq_ram
// generic single-port-write, registered-read ram
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: rtl/mlfq_ctrl.sv
// ---------------------------------------------------------------------------
// mlfq_ctrl
// request sequencer: steps the datapath through scans, push and dispatch
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mlfq_scheduler_core_defines.svh"
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);
    ctrl_state_t state_reg, state_next;
    logic        mv_reg, mv_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                case (st.req)
                    REQ_LOAD: state_next = ST_PUSH;
                    REQ_UNBLOCK: state_next = ST_BSCAN;
                    REQ_TICK: begin
                        if (st.tick_gt1)       state_next = ST_OUT;
                        else if (st.cur_valid) state_next = ST_PUSH;
                        else                   state_next = ST_DSCAN;
                    end
                    REQ_BLOCK: state_next = st.cur_valid ? ST_BSCAN : ST_DSCAN;
                    REQ_EXIT:  state_next = ST_DSCAN;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_BSCAN: begin
                if (st.bscan_hit) begin
                    state_next = (st.req == REQ_UNBLOCK) ? ST_PUSH : ST_DSCAN;
                end else if (st.bscan_done) begin
                    state_next = (st.req == REQ_UNBLOCK) ? ST_OUT : ST_FSCAN;
                end
            end
            ST_FSCAN: if (st.fscan_found || st.fscan_done) state_next = ST_DSCAN;
            ST_PUSH:  state_next = (st.req == REQ_TICK) ? ST_DSCAN : ST_OUT;
            ST_DSCAN: begin
                if (st.disp_found)     state_next = ST_DREAD;
                else if (st.disp_done) state_next = ST_OUT;
            end
            ST_DREAD: state_next = ST_DWAIT;
            ST_DWAIT: state_next = ST_DTAKE;
            ST_DTAKE: state_next = ST_OUT;
            ST_OUT:   if (!mv_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd = '0;
        cmd.push_src = PSRC_LOAD;
        unique case (state_reg)
            ST_IDLE: cmd.latch_req = s_valid;
            ST_DECODE: begin
                cmd.bscan_start = 1'b1;
                cmd.disp_start  = 1'b1;
                cmd.tick_dec    = (st.req == REQ_TICK) && st.tick_gt1;
            end
            ST_BSCAN: begin
                cmd.bscan_step   = !st.bscan_hit;
                cmd.unblock_take = st.bscan_hit && (st.req == REQ_UNBLOCK);
                cmd.fscan_start  = 1'b1;
            end
            ST_FSCAN: begin
                cmd.fscan_step  = !st.fscan_found;
                cmd.block_store = st.fscan_found;
                cmd.set_ovf     = !st.fscan_found && st.fscan_done;
            end
            ST_PUSH: begin
                cmd.push     = 1'b1;
                cmd.set_ovf  = st.push_full;
                cmd.push_src = (st.req == REQ_LOAD) ? PSRC_LOAD :
                               (st.req == REQ_UNBLOCK) ? PSRC_UNBLOCK : PSRC_EXPIRE;
            end
            ST_DSCAN: begin
                cmd.disp_step = !st.disp_found;
                cmd.disp_read = st.disp_found;
                cmd.disp_take = !st.disp_found && st.disp_done;
            end
            ST_DREAD: ;
            ST_DWAIT: ;
            ST_DTAKE: cmd.disp_take = 1'b1;
            ST_OUT:   cmd.out_load = !mv_reg || m_ready;
            default:  ;
        endcase
    end

    // output valid
    always_comb begin
        mv_next = mv_reg;
        if (m_ready) mv_next = 1'b0;
        if (cmd.out_load) mv_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    `MLFQ_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_valid && s_ready, state_reg == ST_DECODE, "accepted word not decoded")
    `MLFQ_ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.out_load, m_valid, "result word lost")
    `MLFQ_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_ready, "ready while busy")
endmodule

FILE: rtl/mlfq_dp.sv
// ---------------------------------------------------------------------------
// mlfq_dp
// scheduler datapath: queues, blocked list, running task and result word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mlfq_scheduler_core_defines.svh"
module mlfq_dp
    import mlfq_pkg::*;
#(
    parameter int NUM_LEVELS    = 4,
    parameter int QUEUE_DEPTH   = 16,
    parameter int BLOCKED_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_task_id,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  st,
    output logic [7:0]  m_running_id,
    output logic        m_running_idle,
    output logic        m_overflow
);
    localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int BW  = $clog2(BLOCKED_DEPTH);
    localparam int BCW = $clog2(BLOCKED_DEPTH + 1);
    localparam int LCW = $clog2(NUM_LEVELS + 1);
    localparam int AW  = $clog2(NUM_LEVELS * QUEUE_DEPTH);

    // configuration
    logic [2:0]  levels_reg;
    logic [15:0] quant_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg   <= 3'd4;
            quant_reg[0] <= 16'd1;
            quant_reg[1] <= 16'd2;
            quant_reg[2] <= 16'd4;
            quant_reg[3] <= 16'd8;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LEVELS: levels_reg   <= cfg_data[2:0];
                CFG_Q0:     quant_reg[0] <= cfg_data;
                CFG_Q1:     quant_reg[1] <= cfg_data;
                CFG_Q2:     quant_reg[2] <= cfg_data;
                CFG_Q3:     quant_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // last level in use
    logic [LW-1:0] last_lvl;
    always_comb begin
        if (levels_reg == 3'd0)
            last_lvl = '0;
        else if (32'(levels_reg) > NUM_LEVELS)
            last_lvl = LW'(NUM_LEVELS - 1);
        else
            last_lvl = LW'(levels_reg - 3'd1);
    end

    // latched request
    logic [2:0] req_reg;
    logic [7:0] id_reg;
    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_reg <= s_req_type;
            id_reg  <= s_task_id;
        end
    end

    // queue state
    logic [QW-1:0] head_reg  [NUM_LEVELS];
    logic [CW-1:0] count_reg [NUM_LEVELS];
    // blocked list
    logic [BLOCKED_DEPTH-1:0] bvalid_reg;
    logic [7:0]    bid_reg  [BLOCKED_DEPTH];
    logic [LW-1:0] blvl_reg [BLOCKED_DEPTH];
    // running task
    logic [7:0]    cur_task_reg;
    logic [LW-1:0] cur_lvl_reg;
    logic          cur_valid_reg;
    logic [15:0]   ticks_reg;
    logic          ovf_reg;

    // blocked list scan
    logic [BCW-1:0] bidx_reg;
    logic [7:0]     bkey;
    logic [BW-1:0]  bsel;
    logic [LW-1:0]  hit_lvl_reg;
    assign bkey = (req_reg == REQ_UNBLOCK) ? id_reg : cur_task_reg;
    assign bsel = bidx_reg[BW-1:0];
    assign st.bscan_done = (bidx_reg == BCW'(BLOCKED_DEPTH - 1));
    assign st.bscan_hit  = bvalid_reg[bsel] && (bid_reg[bsel] == bkey);
    assign st.fscan_done = st.bscan_done;
    assign st.fscan_found = !bvalid_reg[bsel];

    // push level and target
    logic [LW-1:0] push_lvl_raw, push_lvl;
    logic [7:0]    push_id;
    always_comb begin
        case (cmd.push_src)
            PSRC_UNBLOCK: begin
                push_lvl_raw = (hit_lvl_reg != '0) ? hit_lvl_reg - LW'(1) : '0;
                push_id = id_reg;
            end
            PSRC_EXPIRE: begin
                push_lvl_raw = (cur_lvl_reg >= last_lvl) ? last_lvl
                                                         : cur_lvl_reg + LW'(1);
                push_id = cur_task_reg;
            end
            default: begin
                push_lvl_raw = '0;
                push_id = id_reg;
            end
        endcase
        push_lvl = (push_lvl_raw > last_lvl) ? last_lvl : push_lvl_raw;
    end

    // tail slot, wrapped by one compare and subtract
    logic [QW-1:0] push_slot;
    logic [SW-1:0] slot_sum;
    assign st.push_full = (count_reg[push_lvl] == CW'(QUEUE_DEPTH));
    assign slot_sum  = SW'(head_reg[push_lvl]) + SW'(count_reg[push_lvl]);
    assign push_slot = (slot_sum >= SW'(QUEUE_DEPTH)) ? QW'(slot_sum - SW'(QUEUE_DEPTH))
                                                      : QW'(slot_sum);

    // dispatch scan
    logic [LCW-1:0] didx_reg;
    logic [LW-1:0]  dsel;
    logic [LW-1:0]  dlvl_reg;
    assign dsel = didx_reg[LW-1:0];
    assign st.disp_done  = (didx_reg >= LCW'(last_lvl));
    assign st.disp_found = (count_reg[dsel] != '0);

    // ready store ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;
    assign ram_we    = cmd.push && !st.push_full;
    assign ram_waddr = AW'(push_lvl) * AW'(QUEUE_DEPTH) + AW'(push_slot);
    assign ram_raddr = AW'(dlvl_reg) * AW'(QUEUE_DEPTH) + AW'(head_reg[dlvl_reg]);

    mlfq_ram #(.WIDTH(8), .DEPTH(NUM_LEVELS * QUEUE_DEPTH)) u_ready_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (push_id),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    logic [1:0] qsel;
    assign qsel = (dlvl_reg > LW'(3)) ? 2'd3 : 2'(dlvl_reg);

    // scan counters and running state
    always_ff @(posedge aclk) begin
        if (cmd.bscan_start || (cmd.bscan_step && st.bscan_done)
                || (cmd.fscan_start && !cmd.bscan_step)) begin
            bidx_reg <= '0;
        end else if (cmd.bscan_step || cmd.fscan_step) begin
            bidx_reg <= bidx_reg + BCW'(1);
        end
        if (cmd.unblock_take) hit_lvl_reg <= blvl_reg[bsel];
        if (cmd.disp_start) didx_reg <= '0;
        else if (cmd.disp_step) didx_reg <= didx_reg + LCW'(1);
        if (cmd.disp_read) dlvl_reg <= dsel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bvalid_reg    <= '0;
            cur_task_reg  <= '0;
            cur_lvl_reg   <= '0;
            cur_valid_reg <= 1'b0;
            ticks_reg     <= '0;
            ovf_reg       <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            if (cmd.latch_req) ovf_reg <= 1'b0;
            if (cmd.set_ovf) ovf_reg <= 1'b1;
            if (cmd.tick_dec) ticks_reg <= ticks_reg - 16'd1;
            if (cmd.unblock_take) bvalid_reg[bsel] <= 1'b0;
            if (cmd.block_store) begin
                bvalid_reg[bsel] <= 1'b1;
                bid_reg[bsel]    <= cur_task_reg;
                blvl_reg[bsel]   <= (cur_lvl_reg > last_lvl) ? last_lvl : cur_lvl_reg;
            end
            if (ram_we) count_reg[push_lvl] <= count_reg[push_lvl] + CW'(1);
            if (cmd.disp_take) begin
                if (cmd.disp_step || !st.disp_found || cmd.disp_read) begin
                    cur_valid_reg <= 1'b0;
                    cur_task_reg  <= '0;
                    cur_lvl_reg   <= '0;
                    ticks_reg     <= '0;
                end else begin
                    cur_valid_reg <= 1'b1;
                    cur_task_reg  <= ram_rdata;
                    cur_lvl_reg   <= dlvl_reg;
                    ticks_reg     <= (quant_reg[qsel] == '0) ? 16'd1 : quant_reg[qsel];
                    head_reg[dlvl_reg]  <= (head_reg[dlvl_reg] == QW'(QUEUE_DEPTH - 1)) ?
                                           '0 : head_reg[dlvl_reg] + QW'(1);
                    count_reg[dlvl_reg] <= count_reg[dlvl_reg] - CW'(1);
                end
            end
        end
    end

    // status back to controller
    assign st.req       = req_reg;
    assign st.tick_gt1  = (ticks_reg > 16'd1);
    assign st.cur_valid = cur_valid_reg;

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_running_id   <= cur_valid_reg ? cur_task_reg : 8'd0;
            m_running_idle <= !cur_valid_reg;
            m_overflow     <= ovf_reg;
        end
    end

    `MLFQ_ASSERT_IMP(a_push_fits, aclk, aresetn, ram_we, count_reg[push_lvl] < CW'(QUEUE_DEPTH), "push into full queue")
    `MLFQ_ASSERT_IMP(a_idle_zero, aclk, aresetn, !cur_valid_reg, cur_task_reg == 8'd0, "idle with task id")
    `MLFQ_ASSERT_NEXT(a_tick_dec, aclk, aresetn, cmd.tick_dec, ticks_reg == $past(ticks_reg) - 16'd1, "tick not counted")
endmodule

FILE: rtl/mlfq_scheduler_core.sv
// block requests walk the blocked list (match, then free slot if none), one entry a cycle
// dispatch scans one level a cycle, then reads the ready store ram (registered read)
// one request at a time: a new request word is accepted only once the previous one is done
// reset: synchronous active-low aresetn empties all queues and the blocked list, idle
// no clearing pass: ready store entries are only read after being written
// ---------------------------------------------------------------------------
// mlfq_scheduler_core
// multilevel feedback queue scheduler top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mlfq_scheduler_core
    import mlfq_pkg::*;
#(
    parameter int NUM_LEVELS    = 4,
    parameter int QUEUE_DEPTH   = 16,
    parameter int BLOCKED_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_task_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_running_id,
    output logic        m_running_idle,
    output logic        m_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    dp_cmd_t    cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mlfq_dp #(
        .NUM_LEVELS    (NUM_LEVELS),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .BLOCKED_DEPTH (BLOCKED_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_req_type     (s_req_type),
        .s_task_id      (s_task_id),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .st             (st),
        .m_running_id   (m_running_id),
        .m_running_idle (m_running_idle),
        .m_overflow     (m_overflow)
    );
endmodule
